// ----- sv/i2ctrb_pkg.sv -----
// package for the i2c target register buffer: sizes, codes and bus phases
package i2ctrb_pkg;

	localparam int BUF_DEPTH = 16;
	localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	// configuration register indexes, taken from paddr[2]
	localparam logic REG_OWN_ADDRESS = 1'b0;
	localparam logic REG_HOLD_AFTER  = 1'b1;

	typedef enum logic [1:0] {
		OP_PIN_SAMPLE  = 2'd0,
		OP_RELEASE     = 2'd1,
		OP_LOCAL_READ  = 2'd2,
		OP_LOCAL_WRITE = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		PH_IDLE        = 5'd0,
		PH_IDLE_WAIT   = 5'd1,
		PH_STOP_WAIT   = 5'd2,
		PH_STOP_PRE    = 5'd3,
		PH_START       = 5'd4,
		PH_RX_ADDR     = 5'd5,
		PH_RX_PTR      = 5'd6,
		PH_RX_DATA     = 5'd7,
		PH_RX_ADDR_HI  = 5'd8,
		PH_RX_PTR_HI   = 5'd9,
		PH_RX_DATA_HI  = 5'd10,
		PH_ACK_ADDR    = 5'd11,
		PH_ACK_RECV    = 5'd12,
		PH_ACK_SEND    = 5'd13,
		PH_ACK_ADDR_HI = 5'd14,
		PH_ACK_RECV_HI = 5'd15,
		PH_ACK_SEND_HI = 5'd16,
		PH_TX          = 5'd17,
		PH_TX_HI       = 5'd18,
		PH_TX_ACK      = 5'd19
	} phase_t;

endpackage

// ----- sv/i2c_target_register_buffer.sv -----
// i2c target with register pointer and register buffer, stream in / stream out
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tuser: operation; tdata: pins, index, data
//   m_axis    out  m_axis_tvalid/tready       tdata: sda_drive_low, hold_active, read_data
//   apb       in   psel/penable, pready = 1   own_address @0x0, hold_after_receive @0x4
//
// one item per cycle sustained while the result is taken; each item passes from input transfer
// to result through the input register, then through the phase logic into the result register.
// the buffer is a 16 x 8 flop array with one read and one write address per cycle.
// reset clears the bus phase, bit counter, shift register, pointer, hold and the whole buffer at once.
// a stalled result holds the input register; input stays ready while the input register
// is empty, or the result register is empty or being taken.
module i2c_target_register_buffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // scl_level, sda_level, local_index[3:0], local_data[7:0], zero pad
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // sda_drive_low, hold_active, read_data[7:0], zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration
	logic [6:0] own_addr_q;
	logic       hold_cfg_q;

	// input register
	logic                   valid_s1;
	i2ctrb_pkg::op_t        op_s1;
	logic                   scl_s1;
	logic                   sda_s1;
	logic [3:0]             lidx_s1;
	logic [7:0]             ldata_s1;

	// bus state
	i2ctrb_pkg::phase_t phase_q, phase_d;
	logic [3:0] bcnt_q, bcnt_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] ptr_q, ptr_d;
	logic       hold_q, hold_d;
	logic       drv_q, drv_d;
	logic [7:0] regbuf_q [i2ctrb_pkg::BUF_DEPTH];

	// result register
	logic       out_valid_q;
	logic       out_drv_q;
	logic       out_hold_q;
	logic [7:0] out_rd_q;

	logic                          advance;
	logic                          cfg_wr;
	logic                          ptr_ok;
	logic                          idx_ok;
	logic                          shift_ok;
	logic [8:0]                    lidx_w;
	logic [8:0]                    ptr_w;
	logic [i2ctrb_pkg::BUF_AW-1:0] rd_addr;
	logic [7:0]                    rd_byte;
	logic                          wr_en;
	logic [i2ctrb_pkg::BUF_AW-1:0] wr_addr;
	logic [7:0]                    wr_data;
	logic [7:0]                    rd_res;
	logic [3:0]                    bcnt_dec;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == i2ctrb_pkg::REG_HOLD_AFTER) ? {31'b0, hold_cfg_q}
		: {25'b0, own_addr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			hold_cfg_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == i2ctrb_pkg::REG_OWN_ADDRESS) begin
				own_addr_q <= pwdata[6:0];
			end else begin
				hold_cfg_q <= pwdata[0];
			end
		end
	end

	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1    <= i2ctrb_pkg::op_t'(s_axis_tuser);
			scl_s1   <= s_axis_tdata[0];
			sda_s1   <= s_axis_tdata[1];
			lidx_s1  <= s_axis_tdata[5:2];
			ldata_s1 <= s_axis_tdata[13:6];
		end
	end

	assign lidx_w   = 9'(lidx_s1);
	assign ptr_w    = 9'(ptr_q);
	assign ptr_ok   = ptr_w < 9'(i2ctrb_pkg::BUF_DEPTH);
	assign idx_ok   = lidx_w < 9'(i2ctrb_pkg::BUF_DEPTH);
	assign shift_ok = 9'(shift_q) < 9'(i2ctrb_pkg::BUF_DEPTH);
	assign bcnt_dec = bcnt_q - 4'd1;

	// single read port: local read uses the index, the bus uses the pointer
	assign rd_addr = (op_s1 == i2ctrb_pkg::OP_LOCAL_READ) ? lidx_w[i2ctrb_pkg::BUF_AW-1:0]
		: ptr_w[i2ctrb_pkg::BUF_AW-1:0];
	assign rd_byte = regbuf_q[rd_addr];

	always_comb begin
		phase_d = phase_q;
		bcnt_d  = bcnt_q;
		shift_d = shift_q;
		ptr_d   = ptr_q;
		hold_d  = hold_q;
		drv_d   = drv_q;
		wr_en   = 1'b0;
		wr_addr = lidx_w[i2ctrb_pkg::BUF_AW-1:0];
		wr_data = ldata_s1;
		rd_res  = 8'd0;

		unique case (op_s1)
			i2ctrb_pkg::OP_PIN_SAMPLE: begin
				unique case (phase_q) inside
					i2ctrb_pkg::PH_IDLE_WAIT: begin
						if (scl_s1 && sda_s1) phase_d = i2ctrb_pkg::PH_IDLE;
					end
					i2ctrb_pkg::PH_STOP_WAIT: begin
						if (!scl_s1) begin
							phase_d = i2ctrb_pkg::PH_STOP_PRE;
						end else if (sda_s1) begin
							phase_d = i2ctrb_pkg::PH_IDLE;
							if (hold_cfg_q) begin
								hold_d = 1'b1;
								drv_d  = 1'b1;
							end
						end
					end
					i2ctrb_pkg::PH_STOP_PRE: begin
						if (scl_s1 && !sda_s1) phase_d = i2ctrb_pkg::PH_STOP_WAIT;
					end
					i2ctrb_pkg::PH_START: begin
						if (sda_s1) begin
							phase_d = i2ctrb_pkg::PH_IDLE;
						end else if (!scl_s1) begin
							bcnt_d  = 4'd8;
							phase_d = i2ctrb_pkg::PH_RX_ADDR;
						end
					end
					i2ctrb_pkg::PH_RX_ADDR, i2ctrb_pkg::PH_RX_PTR, i2ctrb_pkg::PH_RX_DATA: begin
						if (scl_s1) begin
							shift_d = {shift_q[6:0], sda_s1};
							phase_d = i2ctrb_pkg::phase_t'(phase_q + 5'd3);
						end
					end
					i2ctrb_pkg::PH_RX_ADDR_HI, i2ctrb_pkg::PH_RX_PTR_HI,
					i2ctrb_pkg::PH_RX_DATA_HI: begin
						if (scl_s1) begin
							// sda moving while scl is high: stop or repeated start
							if (!shift_q[0] && sda_s1) begin
								phase_d = i2ctrb_pkg::PH_IDLE;
								if (hold_cfg_q) begin
									hold_d = 1'b1;
									drv_d  = 1'b1;
								end
							end else if (shift_q[0] && !sda_s1) begin
								phase_d = i2ctrb_pkg::PH_START;
							end
						end else begin
							phase_d = i2ctrb_pkg::phase_t'(phase_q - 5'd3);
							if (bcnt_q != 4'd0) begin
								bcnt_d = bcnt_dec;
								if (bcnt_dec == 4'd0) begin
									// full byte in
									if (phase_q == i2ctrb_pkg::PH_RX_ADDR_HI) begin
										if (shift_q[7:1] != own_addr_q) begin
											phase_d = i2ctrb_pkg::PH_IDLE_WAIT;
										end else if (shift_q[0]) begin
											phase_d = i2ctrb_pkg::PH_ACK_SEND;
											if (ptr_ok) drv_d = 1'b1;
										end else begin
											phase_d = i2ctrb_pkg::PH_ACK_ADDR;
											drv_d   = 1'b1;
										end
									end else if (phase_q == i2ctrb_pkg::PH_RX_PTR_HI) begin
										ptr_d   = shift_q;
										phase_d = i2ctrb_pkg::PH_ACK_RECV;
										if (shift_ok) drv_d = 1'b1;
									end else if (ptr_ok) begin
										wr_en   = 1'b1;
										wr_addr = ptr_w[i2ctrb_pkg::BUF_AW-1:0];
										wr_data = shift_q;
										ptr_d   = ptr_q + 8'd1;
										phase_d = i2ctrb_pkg::PH_ACK_RECV;
										drv_d   = 1'b1;
									end
								end
							end
						end
					end
					i2ctrb_pkg::PH_ACK_ADDR, i2ctrb_pkg::PH_ACK_RECV,
					i2ctrb_pkg::PH_ACK_SEND: begin
						if (scl_s1) phase_d = i2ctrb_pkg::phase_t'(phase_q + 5'd3);
					end
					i2ctrb_pkg::PH_ACK_ADDR_HI, i2ctrb_pkg::PH_ACK_RECV_HI,
					i2ctrb_pkg::PH_ACK_SEND_HI: begin
						if (!scl_s1) begin
							if (phase_q == i2ctrb_pkg::PH_ACK_SEND_HI && ptr_ok) begin
								// load next byte and put out its msb
								ptr_d   = ptr_q + 8'd1;
								drv_d   = ~rd_byte[7];
								shift_d = {rd_byte[6:0], 1'b0};
								bcnt_d  = 4'd7;
								phase_d = i2ctrb_pkg::PH_TX;
							end else begin
								drv_d  = 1'b0;
								bcnt_d = 4'd8;
								if (phase_q == i2ctrb_pkg::PH_ACK_ADDR_HI) begin
									phase_d = i2ctrb_pkg::PH_RX_PTR;
								end else if (phase_q == i2ctrb_pkg::PH_ACK_RECV_HI) begin
									phase_d = i2ctrb_pkg::PH_RX_DATA;
								end else begin
									phase_d = i2ctrb_pkg::PH_STOP_PRE;
								end
							end
						end
					end
					i2ctrb_pkg::PH_TX: begin
						if (scl_s1) phase_d = i2ctrb_pkg::PH_TX_HI;
					end
					i2ctrb_pkg::PH_TX_HI: begin
						if (!scl_s1) begin
							drv_d   = (bcnt_q != 4'd0) && !shift_q[7];
							shift_d = {shift_q[6:0], 1'b0};
							if (bcnt_q != 4'd0) begin
								bcnt_d  = bcnt_dec;
								phase_d = i2ctrb_pkg::PH_TX;
							end else begin
								phase_d = i2ctrb_pkg::PH_TX_ACK;
							end
						end
					end
					i2ctrb_pkg::PH_TX_ACK: begin
						if (scl_s1) begin
							phase_d = sda_s1 ? i2ctrb_pkg::PH_IDLE_WAIT
								: i2ctrb_pkg::PH_ACK_SEND_HI;
						end
					end
					default: begin
						if (!scl_s1) begin
							phase_d = i2ctrb_pkg::PH_IDLE_WAIT;
						end else if (!sda_s1) begin
							phase_d = i2ctrb_pkg::PH_START;
						end
					end
				endcase
			end
			i2ctrb_pkg::OP_RELEASE: begin
				if (hold_q) begin
					drv_d  = 1'b0;
					hold_d = 1'b0;
				end
			end
			i2ctrb_pkg::OP_LOCAL_READ: begin
				if (idx_ok) rd_res = rd_byte;
			end
			default: begin
				wr_en = idx_ok;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2ctrb_pkg::PH_IDLE;
			bcnt_q  <= '0;
			shift_q <= '0;
			ptr_q   <= '0;
			hold_q  <= 1'b0;
			drv_q   <= 1'b0;
			for (int i = 0; i < i2ctrb_pkg::BUF_DEPTH; i++) begin
				regbuf_q[i[i2ctrb_pkg::BUF_AW-1:0]] <= '0;
			end
		end else if (advance) begin
			phase_q <= phase_d;
			bcnt_q  <= bcnt_d;
			shift_q <= shift_d;
			ptr_q   <= ptr_d;
			hold_q  <= hold_d;
			drv_q   <= drv_d;
			if (wr_en) regbuf_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_drv_q  <= drv_d;
			out_hold_q <= hold_d;
			out_rd_q   <= rd_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_rd_q, out_hold_q, out_drv_q};

	// the hold always comes with sda pulled low
	a_hold_drives: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hold_q) |-> drv_q)
		else $error("hold set without driving sda");

	// only a local read returns buffer data
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 != i2ctrb_pkg::OP_LOCAL_READ |=> out_rd_q == 8'd0)
		else $error("read data on a non-read item");

	// bit counter never exceeds a full byte
	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= 4'd8)
		else $error("bit counter out of range");

	// a stalled item stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(lidx_s1))
		else $error("stalled input item lost");

endmodule
